// File: hdl/ncos_pkg.sv
// ============================================================================
// ncos_pkg: shared definitions for the nearest catalog object search core
// Field widths, request codes, catalog and alias kinds, register indexes and
// the packed layouts of the catalog and alias store entries.
// ============================================================================
package ncos_pkg;

  // Default store depths.
  localparam int CATALOG_DEPTH_DEF = 16384;
  localparam int ALIAS_DEPTH_DEF   = 1024;

  // Field widths.
  localparam int OP_W          = 2;
  localparam int SLOT_W        = 14;
  localparam int COORD_W       = 16;
  localparam int KIND_W        = 2;
  localparam int OBJ_NUM_W     = 16;
  localparam int ALIAS_NUM_W   = 10;
  localparam int DIST_W        = 33;
  localparam int KEY_W         = 17;
  localparam int CAT_COUNT_W   = 15;
  localparam int ALIAS_COUNT_W = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 15;

  // Wide enough to compare a slot against any supported depth.
  localparam int SLOT_CMP_W = 17;

  // Search constants.
  localparam logic [DIST_W-1:0] INITIAL_BOUND = 33'h0_7fff_ffff;
  localparam logic [KEY_W-1:0]  IC_KEY_OFFSET = 17'd10000;

  // Request codes.
  localparam logic [OP_W-1:0] OP_WR_CATALOG = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_ALIAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

  // Catalog kinds.
  localparam logic [KIND_W-1:0] CAT_STAR  = 2'd0;
  localparam logic [KIND_W-1:0] CAT_NGC   = 2'd1;
  localparam logic [KIND_W-1:0] CAT_IC    = 2'd2;

  // Alias kinds.
  localparam logic [KIND_W-1:0] ALT_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] ALT_MESSIER  = 2'd1;
  localparam logic [KIND_W-1:0] ALT_CALDWELL = 2'd2;
  localparam logic [KIND_W-1:0] ALT_HERSCHEL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CATALOG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIAS_COUNT   = 1'd1;

  // One catalog store entry.
  typedef struct packed {
    logic [COORD_W-1:0]   ra;
    logic [COORD_W-1:0]   dec;
    logic [KIND_W-1:0]    kind;
    logic [OBJ_NUM_W-1:0] number;
  } cat_entry_t;

  // One alias store entry.
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [OBJ_NUM_W-1:0]   key;
    logic [ALIAS_NUM_W-1:0] num;
  } alias_entry_t;

endpackage

// File: hdl/nearest_catalog_object_search_core.sv
// ============================================================================
// nearest_catalog_object_search_core: nearest catalog entry and its alias
// Loads a catalog store and an alias store, then answers position queries by
// a linear scan for the nearest entry followed by an alias lookup.
// ============================================================================
// Usage:
// A request is taken at a rising edge with start high and busy low. Op 0
// writes a catalog entry and op 1 an alias entry; both finish at that edge
// and busy stays low. Op 2 is a query: busy rises and the block scans
// catalog slots 0 .. catalog_count-1, one memory read per cycle, through a
// four-stage distance pipeline with a single running-best compare. It then
// scans alias slots 0 .. alias_count-1, one read per cycle, tracking the
// last Messier, Caldwell and Herschel hit in one pass.
// A query holds busy through the catalog scan and drain and the alias scan
// and drain, with both counts clamped to the store depths. done pulses for one
// cycle with the result, and busy falls in that same cycle. The receiver
// cannot stall, so each result must be captured while done is high.
// Configuration writes use cfg_valid/cfg_ready and are always accepted; they
// must be made only while the block is idle; the block does not enforce this.
// Reset clears both counts and the sequencer; store contents are undefined
// until written and need no clear.
// ============================================================================
module nearest_catalog_object_search_core #(
  parameter int CATALOG_DEPTH = ncos_pkg::CATALOG_DEPTH_DEF,
  parameter int ALIAS_DEPTH   = ncos_pkg::ALIAS_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ncos_pkg::OP_W-1:0]           op,
  input  logic [ncos_pkg::SLOT_W-1:0]         slot,
  input  logic [ncos_pkg::COORD_W-1:0]        ra,
  input  logic signed [ncos_pkg::COORD_W-1:0] dec,
  input  logic [ncos_pkg::KIND_W-1:0]         kind,
  input  logic [ncos_pkg::OBJ_NUM_W-1:0]      object_number,
  input  logic [ncos_pkg::ALIAS_NUM_W-1:0]    alias_number,
  output logic                                done,
  output logic                                found,
  output logic [ncos_pkg::KIND_W-1:0]         best_catalog,
  output logic [ncos_pkg::OBJ_NUM_W-1:0]      best_number,
  output logic [ncos_pkg::DIST_W-1:0]         best_distance,
  output logic [ncos_pkg::KIND_W-1:0]         alt_catalog,
  output logic [ncos_pkg::ALIAS_NUM_W-1:0]    alt_number,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ncos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncos_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ncos_pkg::*;

  localparam int CAW = $clog2(CATALOG_DEPTH);
  localparam int AAW = $clog2(ALIAS_DEPTH);
  localparam int CIW = CAW + 1;
  localparam int AIW = AAW + 1;
  localparam int CCW = (CIW > CAT_COUNT_W) ? CIW : CAT_COUNT_W;
  localparam int ACW = (AIW > ALIAS_COUNT_W) ? AIW : ALIAS_COUNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CSCAN  = 3'd1;
  localparam logic [2:0] S_CDRAIN = 3'd2;
  localparam logic [2:0] S_ASCAN  = 3'd3;
  localparam logic [2:0] S_ADRAIN = 3'd4;

  logic [2:0]               state;
  logic [CAT_COUNT_W-1:0]   catalog_count;
  logic [ALIAS_COUNT_W-1:0] alias_count;
  logic [CIW-1:0]           cidx;
  logic [AIW-1:0]           aidx;

  cat_entry_t   cat_mem [CATALOG_DEPTH];
  alias_entry_t alias_mem [ALIAS_DEPTH];
  cat_entry_t   cat_q;
  alias_entry_t alias_q;

  logic [COORD_W-1:0]        tra;
  logic [COORD_W-1:0]        tdec;
  logic                      cv1, cv2, cv3, av1;
  logic [COORD_W-1:0]        dra_abs, ddec_abs;
  logic [2*COORD_W-1:0]      sq_ra, sq_dec;
  logic [KIND_W-1:0]         kind2, kind3;
  logic [OBJ_NUM_W-1:0]      num2, num3;
  logic [DIST_W-1:0]         best;
  logic                      found_r;
  logic [KIND_W-1:0]         bkind;
  logic [OBJ_NUM_W-1:0]      bnum;
  logic [KEY_W-1:0]          key;
  logic                      hit_m, hit_c, hit_h;
  logic [ALIAS_NUM_W-1:0]    num_m, num_c, num_h;

  logic                      accept;
  logic [CCW-1:0]            cat_lim;
  logic [ACW-1:0]            alias_lim;
  logic                      cat_issue, alias_issue;
  logic signed [COORD_W:0]   dr, dd;
  logic [COORD_W-1:0]        dra_abs_next, ddec_abs_next;
  logic [2*COORD_W-1:0]      sq_ra_next, sq_dec_next;
  logic [DIST_W-1:0]         dist_sum;
  logic [KEY_W-1:0]          key_next;
  logic                      alias_m, alias_c, alias_h;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective scan lengths, clamped to the store depths.
  assign cat_lim = (CCW'(catalog_count) > CCW'(CATALOG_DEPTH)) ?
                   CCW'(CATALOG_DEPTH) : CCW'(catalog_count);
  assign alias_lim = (ACW'(alias_count) > ACW'(ALIAS_DEPTH)) ?
                     ACW'(ALIAS_DEPTH) : ACW'(alias_count);
  assign cat_issue   = (state == S_CSCAN) && (CCW'(cidx) < cat_lim);
  assign alias_issue = (state == S_ASCAN) && (ACW'(aidx) < alias_lim);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      catalog_count <= '0;
      alias_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CATALOG_COUNT: catalog_count <= cfg_data;
        CFG_ALIAS_COUNT:   alias_count   <= cfg_data[ALIAS_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Catalog store: written by load requests, read once per scan cycle.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_CATALOG) &&
        (SLOT_CMP_W'(slot) < SLOT_CMP_W'(CATALOG_DEPTH))) begin
      cat_mem[CAW'(slot)] <= '{ra: ra, dec: dec, kind: kind, number: object_number};
    end
    if (cat_issue) begin
      cat_q <= cat_mem[cidx[CAW-1:0]];
    end
  end

  // Alias store: written by load requests, read once per scan cycle.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_ALIAS) &&
        (SLOT_CMP_W'(slot) < SLOT_CMP_W'(ALIAS_DEPTH))) begin
      alias_mem[AAW'(slot)] <= '{kind: kind, key: object_number, num: alias_number};
    end
    if (alias_issue) begin
      alias_q <= alias_mem[aidx[AAW-1:0]];
    end
  end

  // Absolute coordinate differences; both fit in 16 bits.
  assign dr = $signed({1'b0, cat_q.ra}) - $signed({1'b0, tra});
  assign dd = $signed({cat_q.dec[COORD_W-1], cat_q.dec}) -
              $signed({tdec[COORD_W-1], tdec});
  assign dra_abs_next  = dr[COORD_W] ? COORD_W'(-dr) : dr[COORD_W-1:0];
  assign ddec_abs_next = dd[COORD_W] ? COORD_W'(-dd) : dd[COORD_W-1:0];

  // Squaring unit and the distance sum.
  assign sq_ra_next  = dra_abs * dra_abs;
  assign sq_dec_next = ddec_abs * ddec_abs;
  assign dist_sum    = DIST_W'(sq_ra) + DIST_W'(sq_dec);

  // Alias key: IC numbers are offset by 10000 so they do not collide with NGC numbers below 10000.
  assign key_next = KEY_W'(bnum) + ((bkind == CAT_IC) ? IC_KEY_OFFSET : '0);

  // Per-class alias hits for the entry in the read register.
  assign alias_m = av1 && (alias_q.kind == ALT_MESSIER)  && (KEY_W'(alias_q.key) == key);
  assign alias_c = av1 && (alias_q.kind == ALT_CALDWELL) && (KEY_W'(alias_q.key) == key);
  assign alias_h = av1 && (alias_q.kind == ALT_HERSCHEL) && (KEY_W'(alias_q.key) == key);

  // Distance pipeline payload.
  always_ff @(posedge clk) begin
    dra_abs  <= dra_abs_next;
    ddec_abs <= ddec_abs_next;
    kind2    <= cat_q.kind;
    num2     <= cat_q.number;
    sq_ra    <= sq_ra_next;
    sq_dec   <= sq_dec_next;
    kind3    <= kind2;
    num3     <= num2;
  end

  // Sequencer, running best and alias tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cidx    <= '0;
      aidx    <= '0;
      cv1     <= 1'b0;
      cv2     <= 1'b0;
      cv3     <= 1'b0;
      av1     <= 1'b0;
      found_r <= 1'b0;
      hit_m   <= 1'b0;
      hit_c   <= 1'b0;
      hit_h   <= 1'b0;
      done    <= 1'b0;
    end else begin
      cv1  <= cat_issue;
      cv2  <= cv1;
      cv3  <= cv2;
      av1  <= alias_issue;
      done <= 1'b0;

      // Keep the first entry strictly below the running best.
      if (cv3 && (dist_sum < best)) begin
        best    <= dist_sum;
        found_r <= 1'b1;
        bkind   <= kind3;
        bnum    <= num3;
      end

      // Last matching slot of each class wins.
      if (alias_m) begin
        hit_m <= 1'b1;
        num_m <= alias_q.num;
      end
      if (alias_c) begin
        hit_c <= 1'b1;
        num_c <= alias_q.num;
      end
      if (alias_h) begin
        hit_h <= 1'b1;
        num_h <= alias_q.num;
      end

      case (state)
        S_IDLE: begin
          if (accept && (op == OP_QUERY)) begin
            tra     <= ra;
            tdec    <= dec;
            best    <= INITIAL_BOUND;
            found_r <= 1'b0;
            bkind   <= CAT_STAR;
            bnum    <= '0;
            hit_m   <= 1'b0;
            hit_c   <= 1'b0;
            hit_h   <= 1'b0;
            cidx    <= '0;
            state   <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (cat_issue) begin
            cidx <= cidx + 1'b1;
          end else begin
            state <= S_CDRAIN;
          end
        end
        S_CDRAIN: begin
          if (!cv1 && !cv2 && !cv3) begin
            key   <= key_next;
            aidx  <= '0;
            state <= S_ASCAN;
          end
        end
        S_ASCAN: begin
          if (alias_issue) begin
            aidx <= aidx + 1'b1;
          end else begin
            state <= S_ADRAIN;
          end
        end
        S_ADRAIN: begin
          if (!av1) begin
            done          <= 1'b1;
            found         <= found_r;
            best_catalog  <= bkind;
            best_number   <= bnum;
            best_distance <= found_r ? best : '0;
            alt_catalog   <= ALT_NONE;
            alt_number    <= '0;
            if (found_r && (bkind != CAT_STAR)) begin
              if (hit_m) begin
                alt_catalog <= ALT_MESSIER;
                alt_number  <= num_m;
              end else if (hit_c) begin
                alt_catalog <= ALT_CALDWELL;
                alt_number  <= num_c;
              end else if ((bkind == CAT_NGC) && hit_h) begin
                alt_catalog <= ALT_HERSCHEL;
                alt_number  <= num_h;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A query request always starts a scan.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_QUERY)) |=> busy)
    else $error("query request did not start a scan");

  // A result is only reported as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE) && $past(state == S_ADRAIN))
    else $error("result strobe outside the end of a query");

  // A miss reports a zero distance and no alias.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (best_distance == '0) && (alt_catalog == ALT_NONE) &&
                         (alt_number == '0))
    else $error("miss result carries nonzero fields");

  // A hit always lies below the initial bound.
  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (best_distance < INITIAL_BOUND))
    else $error("reported distance not below the initial bound");

  // Aliases only for non-star hits, Herschel only for NGC entries.
  a_alias_kind: assert property (@(posedge clk) disable iff (rst)
    (done && (alt_catalog != ALT_NONE)) |->
      found && (best_catalog != CAT_STAR) &&
      ((alt_catalog != ALT_HERSCHEL) || (best_catalog == CAT_NGC)))
    else $error("alias reported for an ineligible match");
`endif

endmodule
